>>> src/rcdt_pkg.sv
// Shared types and constants for the rectangle clip and damage tracker.
// Used by the channel interfaces, the front, queue and back stages and the top level.
package rcdt_pkg;

  localparam int BYTES_PER_PIXEL = 4;
  localparam int COORD_BITS      = 16;
  localparam int SURF_BITS       = 14;
  localparam int PITCH_BITS      = 17;
  localparam int GPITCH_BITS     = 16;
  localparam int SKIP_BITS       = COORD_BITS + 1;
  localparam int OFFS_BITS       = 32;
  localparam int CFG_DATA_BITS   = 17;
  localparam int CFG_IDX_BITS    = 2;
  localparam int QUEUE_DEPTH     = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_PITCH      = 2'd2;

  localparam logic [SURF_BITS-1:0]  SURFACE_WIDTH_RESET  = 14'd640;
  localparam logic [SURF_BITS-1:0]  SURFACE_HEIGHT_RESET = 14'd480;
  localparam logic [PITCH_BITS-1:0] ROW_PITCH_RESET      = 17'd2560;

  // Command codes on the mode field
  typedef enum logic [2:0] {
    MODE_FILL    = 3'd0,
    MODE_HLINE   = 3'd1,
    MODE_VLINE   = 3'd2,
    MODE_GLYPH   = 3'd3,
    MODE_CLEAR   = 3'd4,
    MODE_PRESENT = 3'd5,
    MODE_SCROLL  = 3'd6,
    MODE_IGNORE  = 3'd7
  } mode_t;

  // Work class handed from front to back
  typedef enum logic [2:0] {
    OP_FILL    = 3'd0,
    OP_GLYPH   = 3'd1,
    OP_SPAN    = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_PRESENT = 3'd4,
    OP_SCROLL  = 3'd5,
    OP_NOP     = 3'd6
  } op_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    op_t                    op;
    logic                   ok;
    logic [SURF_BITS-1:0]   cl;
    logic [SURF_BITS-1:0]   ct;
    logic [SURF_BITS-1:0]   cr;
    logic [SURF_BITS-1:0]   cb;
    logic [SKIP_BITS-1:0]   sx;
    logic [SKIP_BITS-1:0]   sy;
    logic [GPITCH_BITS-1:0] gp;
  } fe_item_t;

endpackage

>>> src/rcdt_cmd_if.sv
// Command channel: valid/ready handshake with the drawing command fields.
// Depends on rcdt_pkg for field widths.
interface rcdt_cmd_if
  import rcdt_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [2:0]             mode;
  coord_t                 left;
  coord_t                 top;
  coord_t                 right;
  coord_t                 bottom;
  logic signed [15:0]     span_length;
  logic [GPITCH_BITS-1:0] glyph_pitch;

  modport source (
    output valid, mode, left, top, right, bottom, span_length, glyph_pitch,
    input  ready
  );
  modport sink (
    input  valid, mode, left, top, right, bottom, span_length, glyph_pitch,
    output ready
  );
endinterface

>>> src/rcdt_res_if.sv
// Result channel: valid/ready handshake with clip, offset and damage fields.
// Depends on rcdt_pkg for field widths.
interface rcdt_res_if
  import rcdt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 drawn;
  logic [SURF_BITS-1:0] clip_left;
  logic [SURF_BITS-1:0] clip_top;
  logic [SURF_BITS-1:0] clip_right;
  logic [SURF_BITS-1:0] clip_bottom;
  logic [OFFS_BITS-1:0] dest_offset;
  logic [OFFS_BITS-1:0] source_offset;
  coord_t               damage_left;
  coord_t               damage_top;
  coord_t               damage_right;
  coord_t               damage_bottom;
  logic                 surface_dirty;

  modport source (
    output valid, drawn, clip_left, clip_top, clip_right, clip_bottom, dest_offset,
           source_offset, damage_left, damage_top, damage_right, damage_bottom,
           surface_dirty,
    input  ready
  );
  modport sink (
    input  valid, drawn, clip_left, clip_top, clip_right, clip_bottom, dest_offset,
           source_offset, damage_left, damage_top, damage_right, damage_bottom,
           surface_dirty,
    output ready
  );
endinterface

>>> src/rcdt_front.sv
// Front stage: accepts commands, clips shapes against the surface, classifies the work.
// Depends on rcdt_pkg and rcdt_cmd_if.
module rcdt_front
  import rcdt_pkg::*;
(
  rcdt_cmd_if.sink              cmd,
  input  logic [SURF_BITS-1:0]  surface_width,
  input  logic [SURF_BITS-1:0]  surface_height,
  input  logic                  queue_full,
  output logic                  push,
  output fe_item_t              item
);

  typedef logic signed [COORD_BITS+1:0] wide_t;

  wide_t l, t, r, b, len, w, h;
  wide_t bl, bt, br, bb, e;
  logic  ok;
  op_t   op;

  // Accept whenever the queue has room
  assign cmd.ready = !queue_full;
  assign push      = cmd.valid && !queue_full;

  assign l   = wide_t'(cmd.left);
  assign t   = wide_t'(cmd.top);
  assign r   = wide_t'(cmd.right);
  assign b   = wide_t'(cmd.bottom);
  assign len = wide_t'(cmd.span_length);
  assign w   = wide_t'({1'b0, surface_width});
  assign h   = wide_t'({1'b0, surface_height});

  // Clip the shape and pick the work class
  always_comb begin
    ok = 1'b0;
    op = OP_NOP;
    bl = '0;
    bt = '0;
    br = '0;
    bb = '0;
    e  = '0;
    case (mode_t'(cmd.mode))
      MODE_FILL, MODE_GLYPH: begin
        op = (mode_t'(cmd.mode) == MODE_GLYPH) ? OP_GLYPH : OP_FILL;
        bl = (l < 0) ? '0 : l;
        bt = (t < 0) ? '0 : t;
        br = (r > w) ? w : r;
        bb = (b > h) ? h : b;
        ok = !(l > r) && !(t > b) && (l < w) && (t < h) && !(r < 0) && !(b < 0) &&
             (bl != br) && (bt != bb);
      end
      MODE_HLINE: begin
        op = OP_SPAN;
        e  = l + len;
        bl = (l < 0) ? '0 : l;
        br = (e > w) ? w : e;
        bt = t;
        bb = t + wide_t'(1);
        ok = (t >= 0) && (t < h) && (len > 0) && (l < w) && (e > 0);
      end
      MODE_VLINE: begin
        op = OP_SPAN;
        e  = t + len;
        bt = (t < 0) ? '0 : t;
        bb = (e > h) ? h : e;
        bl = l;
        br = l + wide_t'(1);
        ok = (l >= 0) && (l < w) && (len > 0) && (t < h) && (e > 0);
      end
      MODE_CLEAR:   op = OP_CLEAR;
      MODE_PRESENT: op = OP_PRESENT;
      MODE_SCROLL:  op = OP_SCROLL;
      default:      op = OP_NOP;
    endcase
  end

  // Pack the queue entry; skipped glyph rows/columns are only used for glyphs
  always_comb begin
    item.op = op;
    item.ok = ok;
    item.cl = bl[SURF_BITS-1:0];
    item.ct = bt[SURF_BITS-1:0];
    item.cr = br[SURF_BITS-1:0];
    item.cb = bb[SURF_BITS-1:0];
    item.sx = SKIP_BITS'(bl - l);
    item.sy = SKIP_BITS'(bt - t);
    item.gp = cmd.glyph_pitch;
  end

endmodule

>>> src/rcdt_queue.sv
// Short queue between front and back stages so each side stalls on its own.
// Depends on rcdt_pkg for the entry type and depth.
module rcdt_queue
  import rcdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fe_item_t din,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output fe_item_t dout
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  fe_item_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full      = (count == CntW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign dout      = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

>>> src/rcdt_back.sv
// Back stage: updates damage and dirty state, forms byte offsets, holds the result register.
// Depends on rcdt_pkg and rcdt_res_if.
module rcdt_back
  import rcdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SURF_BITS-1:0]  surface_width,
  input  logic [SURF_BITS-1:0]  surface_height,
  input  logic [PITCH_BITS-1:0] row_pitch_bytes,
  input  logic                  item_valid,
  input  fe_item_t              item,
  output logic                  pop,
  rcdt_res_if.source            res
);

  coord_t dmg_left, dmg_top, dmg_right, dmg_bottom;
  coord_t dmg_left_next, dmg_top_next, dmg_right_next, dmg_bottom_next;
  logic   dirty, dirty_next;
  logic   widen;
  coord_t cl_c, ct_c, cr_c, cb_c;

  logic [PITCH_BITS+SURF_BITS-1:0]  dest_prod;
  logic [GPITCH_BITS+SKIP_BITS-1:0] src_prod;
  logic [OFFS_BITS-1:0]             dest_sum, src_sum;

  logic                 out_valid;
  logic                 out_drawn;
  logic [SURF_BITS-1:0] out_cl, out_ct, out_cr, out_cb;
  logic [OFFS_BITS-1:0] out_dest, out_src;

  // Take the next entry when the result register is free or being drained
  assign pop = item_valid && (!out_valid || res.ready);

  assign cl_c  = coord_t'(item.cl);
  assign ct_c  = coord_t'(item.ct);
  assign cr_c  = coord_t'(item.cr);
  assign cb_c  = coord_t'(item.cb);
  assign widen = item.ok && (item.op == OP_FILL || item.op == OP_GLYPH);

  // Damage union and dirty flag
  always_comb begin
    dmg_left_next   = dmg_left;
    dmg_top_next    = dmg_top;
    dmg_right_next  = dmg_right;
    dmg_bottom_next = dmg_bottom;
    dirty_next      = dirty;
    case (item.op)
      OP_FILL, OP_GLYPH: begin
        if (widen) begin
          if (cl_c < dmg_left)   dmg_left_next   = cl_c;
          if (ct_c < dmg_top)    dmg_top_next    = ct_c;
          if (cr_c > dmg_right)  dmg_right_next  = cr_c;
          if (cb_c > dmg_bottom) dmg_bottom_next = cb_c;
          dirty_next = 1'b1;
        end
      end
      OP_CLEAR: begin
        dmg_left_next   = '0;
        dmg_top_next    = '0;
        dmg_right_next  = coord_t'(surface_width);
        dmg_bottom_next = coord_t'(surface_height);
        dirty_next      = 1'b1;
      end
      OP_PRESENT: dirty_next = 1'b0;
      OP_SCROLL:  dirty_next = 1'b1;
      default: begin
      end
    endcase
  end

  // Destination and glyph source offsets, modulo 2^32
  assign dest_prod = row_pitch_bytes * item.ct;
  assign src_prod  = item.gp * item.sy;
  assign dest_sum  = OFFS_BITS'(dest_prod) + OFFS_BITS'(item.cl) * OFFS_BITS'(BYTES_PER_PIXEL);
  assign src_sum   = OFFS_BITS'(src_prod) + OFFS_BITS'(item.sx);

  // Hold state and result control
  always_ff @(posedge clk) begin
    if (rst) begin
      dmg_left   <= '0;
      dmg_top    <= '0;
      dmg_right  <= '0;
      dmg_bottom <= '0;
      dirty      <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        dmg_left   <= dmg_left_next;
        dmg_top    <= dmg_top_next;
        dmg_right  <= dmg_right_next;
        dmg_bottom <= dmg_bottom_next;
        dirty      <= dirty_next;
        out_valid  <= 1'b1;
      end else if (res.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Load result payload; rejected shapes and non-drawing commands report zeros
  always_ff @(posedge clk) begin
    if (pop) begin
      out_drawn <= item.ok;
      out_cl    <= item.ok ? item.cl : '0;
      out_ct    <= item.ok ? item.ct : '0;
      out_cr    <= item.ok ? item.cr : '0;
      out_cb    <= item.ok ? item.cb : '0;
      out_dest  <= item.ok ? dest_sum : '0;
      out_src   <= (item.ok && item.op == OP_GLYPH) ? src_sum : '0;
    end
  end

  assign res.valid         = out_valid;
  assign res.drawn         = out_drawn;
  assign res.clip_left     = out_cl;
  assign res.clip_top      = out_ct;
  assign res.clip_right    = out_cr;
  assign res.clip_bottom   = out_cb;
  assign res.dest_offset   = out_dest;
  assign res.source_offset = out_src;
  assign res.damage_left   = dmg_left;
  assign res.damage_top    = dmg_top;
  assign res.damage_right  = dmg_right;
  assign res.damage_bottom = dmg_bottom;
  assign res.surface_dirty = dirty;

endmodule

>>> src/rect_clip_damage_tracker_top.sv
// Rectangle clip and damage tracker: one command in, one result out per command.
// Depends on rcdt_pkg, the channel interfaces, rcdt_front, rcdt_queue and rcdt_back.
//
// Takes one drawing command per clock while the queue has room and returns one result
// per command, in order. The front clips each command against the surface in the cycle
// it is transferred and writes it to a two-entry queue; the back updates the damage
// rectangle and dirty flag, forms the destination offset (row pitch times top plus
// four bytes per pixel) and the glyph source offset with one multiplier each, and
// loads the result register, which is valid on the following cycle. The damage and
// dirty fields reflect the state after the command. Configuration writes take
// effect at once and must be made while no command is in flight.
module rect_clip_damage_tracker_top
  import rcdt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  rcdt_cmd_if.sink                 cmd,
  rcdt_res_if.source               res
);

  logic [SURF_BITS-1:0]  surface_width;
  logic [SURF_BITS-1:0]  surface_height;
  logic [PITCH_BITS-1:0] row_pitch_bytes;

  logic     push, pop, queue_full, queue_not_empty;
  fe_item_t fe_item, be_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width   <= SURFACE_WIDTH_RESET;
      surface_height  <= SURFACE_HEIGHT_RESET;
      row_pitch_bytes <= ROW_PITCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SURFACE_WIDTH:  surface_width   <= cfg_data[SURF_BITS-1:0];
        CFG_SURFACE_HEIGHT: surface_height  <= cfg_data[SURF_BITS-1:0];
        CFG_ROW_PITCH:      row_pitch_bytes <= cfg_data[PITCH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rcdt_front u_front (
    .cmd            (cmd),
    .surface_width  (surface_width),
    .surface_height (surface_height),
    .queue_full     (queue_full),
    .push           (push),
    .item           (fe_item)
  );

  rcdt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (fe_item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .dout      (be_item)
  );

  rcdt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .surface_width   (surface_width),
    .surface_height  (surface_height),
    .row_pitch_bytes (row_pitch_bytes),
    .item_valid      (queue_not_empty),
    .item            (be_item),
    .pop             (pop),
    .res             (res)
  );

endmodule
